@@ rtl/pra_pkg.sv @@
// Package for the precision-recall area unit: sizes, payload structs,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pra_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int SCORE_BITS = 16;
    localparam int CLASS_BITS = 8;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int AREA_W     = 17;
    localparam int ACC_W      = 40;
    localparam int DEN_W      = CNT_W + 1;
    localparam int KEY_W      = SCORE_BITS + ADDR_W;
    localparam int FRAC_BITS  = 16;

    // One input beat.
    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic [CLASS_BITS-1:0] true_class;
        logic                  last_item;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              no_positives;
        logic              overflowed;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INIT_DIV,
        S_INIT_WAIT,
        S_SCAN_GO,
        S_SCAN,
        S_STEP_DIV,
        S_STEP_WAIT,
        S_FIN_DIV,
        S_FIN_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic div_go;
        logic div_final;
        logic set_qprev;
        logic scan_start;
        logic scan_run;
        logic step;
        logic accum;
        logic publish;
        logic pub_div;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic no_pos;
        logic small_set;
        logic div_done;
        logic scan_done;
        logic walk_done;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/pra_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on pra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pra_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_go,
    input  wire logic [pra_pkg::ACC_W-1:0] i_num,
    input  wire logic [pra_pkg::DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic      [pra_pkg::ACC_W-1:0] o_quo
);
    import pra_pkg::*;

    localparam int IT_W = $clog2(ACC_W + 1);

    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [ACC_W-1:0] r_quo;
    logic [IT_W-1:0]  r_it;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem2;
    logic             ge;

    // One trial subtraction per cycle.
    always_comb begin
        rem2  = {r_rem, r_quo[ACC_W-1]};
        ge    = (rem2 >= {1'b0, r_den});
        n_rem = ge ? DEN_W'(rem2 - {1'b0, r_den}) : rem2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_it   <= '0;
            end else if (r_busy) begin
                r_it <= r_it + 1'b1;
                if (r_it == IT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ACC_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

@@ rtl/pra_ctrl.sv @@
// Controller state machine for the precision-recall area unit.
// Depends on pra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pra_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_last,
    input  wire pra_pkg::t_status i_status,
    output pra_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    import pra_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.no_pos || i_status.small_set) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = S_INIT_DIV;
                end
            end
            S_INIT_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.set_qprev = 1'b1;
                    n_state         = S_SCAN_GO;
                end
            end
            S_SCAN_GO: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_STEP_DIV;
                end
            end
            S_STEP_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_STEP_WAIT;
            end
            S_STEP_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.accum = 1'b1;
                    n_state     = i_status.walk_done ? S_FIN_DIV : S_SCAN_GO;
                end
            end
            S_FIN_DIV: begin
                o_cmd.div_go    = 1'b1;
                o_cmd.div_final = 1'b1;
                n_state         = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.publish = 1'b1;
                    o_cmd.pub_div = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // Checks on controller behavior.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy) else $error("load while busy");
    a_check_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_last) |=> (r_state == S_CHECK)) else $error("last beat lost");
    a_pub_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> !o_busy) else $error("publish did not end the pass");

endmodule
`default_nettype wire

@@ rtl/pra_dp.sv @@
// Datapath: item store, counters, min-key scan, precision walk and result register.
// Depends on pra_pkg and pra_div.
`timescale 1ns / 1ps
`default_nettype none
module pra_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pra_pkg::t_item                 i_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [pra_pkg::CLASS_BITS-1:0] i_cfg_wdata,
    input  wire pra_pkg::t_cmd                  i_cmd,
    output pra_pkg::t_status                    o_status,
    output pra_pkg::t_result                    o_result,
    output logic                                o_res_strobe
);
    import pra_pkg::*;

    localparam logic [AREA_W-1:0] ONE_Q = AREA_W'(1 << FRAC_BITS);

    // Store: label bit above the score.
    logic [SCORE_BITS:0] r_mem [MAX_ITEMS];

    logic [CLASS_BITS-1:0] r_tc;
    logic [CNT_W-1:0]      r_cnt, r_pos, r_tp, r_pp, r_step, r_scan_j;
    logic                  r_ovf;
    logic [ACC_W-1:0]      r_acc;
    logic [AREA_W-1:0]     r_qprev;
    logic                  r_rd_vld, r_best_vld, r_best_lbl, r_have_prev;
    logic [ADDR_W-1:0]     r_rd_idx;
    logic [SCORE_BITS:0]   r_rd_data;
    logic [KEY_W-1:0]      r_best_key, r_prev_key, rd_key;
    logic                  take;
    logic                  r_res_vld;
    t_result               r_res;
    logic [ACC_W-1:0]      div_num, div_quo;
    logic [DEN_W-1:0]      div_den;
    logic                  div_done;
    logic [AREA_W-1:0]     q_now, fin_area;
    logic                  is_pos;

    assign is_pos = (i_item.true_class == r_tc);

    // Target class register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
        end else if (i_cfg_we) begin
            r_tc <= i_cfg_wdata;
        end
    end

    // Store write and memory read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_cnt < CNT_W'(MAX_ITEMS))) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= {is_pos, i_item.score};
        end
        r_rd_data <= r_mem[r_scan_j[ADDR_W-1:0]];
    end

    // Candidate key: score then arrival index, so equal scores keep order.
    assign rd_key = {r_rd_data[SCORE_BITS-1:0], r_rd_idx};
    assign take   = r_rd_vld && (!r_have_prev || (rd_key > r_prev_key))
                    && (!r_best_vld || (rd_key < r_best_key));

    // Divider operands.
    always_comb begin
        if (i_cmd.div_final) begin
            div_num = r_acc + ACC_W'(r_pos);
            div_den = {r_pos, 1'b0};
        end else begin
            div_num = (ACC_W'(r_tp) << (FRAC_BITS + 1)) + ACC_W'(r_pp);
            div_den = {r_pp, 1'b0};
        end
    end

    pra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign q_now    = div_quo[AREA_W-1:0];
    assign fin_area = (div_quo > ACC_W'(ONE_Q)) ? ONE_Q : div_quo[AREA_W-1:0];

    // Counters, walk state and scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_acc       <= '0;
            r_tp        <= '0;
            r_pp        <= '0;
            r_step      <= '0;
            r_scan_j    <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_have_prev <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.publish;
            if (i_cmd.load) begin
                if (r_cnt < CNT_W'(MAX_ITEMS)) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (is_pos) r_pos <= r_pos + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.init) begin
                r_tp        <= r_pos;
                r_pp        <= r_cnt;
                r_step      <= '0;
                r_acc       <= '0;
                r_have_prev <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_scan_j   <= '0;
                r_rd_vld   <= 1'b0;
                r_best_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                if (r_scan_j < r_cnt) begin
                    r_scan_j <= r_scan_j + 1'b1;
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (take) r_best_vld <= 1'b1;
            end
            if (i_cmd.step) begin
                r_pp        <= r_pp - 1'b1;
                r_step      <= r_step + 1'b1;
                r_have_prev <= 1'b1;
                if (r_best_lbl && (r_tp != '0)) r_tp <= r_tp - 1'b1;
            end
            if (i_cmd.accum && r_best_lbl) begin
                r_acc <= r_acc + ACC_W'(r_qprev) + ACC_W'(q_now);
            end
            if (i_cmd.publish) begin
                r_cnt <= '0;
                r_pos <= '0;
                r_ovf <= 1'b0;
                r_acc <= '0;
            end
        end
    end

    // Payload registers of the scan and the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run) begin
            r_rd_idx <= r_scan_j[ADDR_W-1:0];
            if (take) begin
                r_best_key <= rd_key;
                r_best_lbl <= r_rd_data[SCORE_BITS];
            end
        end
        if (i_cmd.step) r_prev_key <= r_best_key;
        if (i_cmd.set_qprev || i_cmd.accum) r_qprev <= q_now;
        if (i_cmd.publish) begin
            r_res.area         <= i_cmd.pub_div ? fin_area : '0;
            r_res.no_positives <= (r_pos == '0);
            r_res.overflowed   <= r_ovf;
        end
    end

    assign o_status.no_pos    = (r_pos == '0);
    assign o_status.small_set = (r_cnt <= CNT_W'(1));
    assign o_status.div_done  = div_done;
    assign o_status.scan_done = (r_scan_j == r_cnt) && !r_rd_vld;
    assign o_status.walk_done = (r_step == r_cnt - 1'b1);
    assign o_result           = r_res;
    assign o_res_strobe       = r_res_vld;

    // Checks on datapath behavior.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe) else $error("result held for two cycles");
    a_nopos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.no_positives) |-> (o_result.area == '0))
        else $error("area with no positives");
    a_tp_le_pp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tp <= r_pp) else $error("true positives exceed predicted positives");
    a_step_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_best_vld) else $error("scan found no item");

endmodule
`default_nettype wire

@@ rtl/precision_recall_area_unit.sv @@
// Top level of the precision-recall area unit: controller plus datapath.
// Depends on pra_pkg, pra_ctrl, pra_dp (and pra_div below it).
//
//   Channel  | Ports                       | Handshake
//   ---------+-----------------------------+-----------------------------------
//   item in  | i_item (t_item)             | beat taken when start && !busy
//   config   | i_cfg_we, i_cfg_wdata       | written on any edge with i_cfg_we
//   result   | o_result (t_result)         | one cycle, marked by o_res_strobe
//
// Items that are not last are taken one per cycle; busy stays low.
// After the last item: a check state, one division, then per walk step a scan over
// the store plus a division, then a final division, and then the result beat for
// the n stored items. The check alone ends the pass, with no division, when the set
// has no positives or fewer than two items.
// Reset is synchronous and clears counters, target class and controller.
// The result beat cannot be stalled; a new item may be taken in its cycle.
`timescale 1ns / 1ps
`default_nettype none
module precision_recall_area_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire pra_pkg::t_item                 i_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [pra_pkg::CLASS_BITS-1:0] i_cfg_wdata,
    output pra_pkg::t_result                    o_result,
    output logic                                o_res_strobe
);
    import pra_pkg::*;

    t_cmd    cmd;
    t_status status;

    pra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last_item),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pra_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_result     (o_result),
        .o_res_strobe (o_res_strobe)
    );

endmodule
`default_nettype wire

@@ test/precision_recall_area_checker.sv @@
// Checker for the precision-recall area unit: watches item, config and result beats,
// predicts each data set's area and flags, and compares every result beat field by field.
// Depends on pra_pkg.
`timescale 1ns / 1ps
module precision_recall_area_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire pra_pkg::t_item                 i_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [pra_pkg::CLASS_BITS-1:0] i_cfg_wdata,
    input  wire pra_pkg::t_result               i_result,
    input  wire logic                           i_res_strobe,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import pra_pkg::*;

    // Shadow of the block's item store and counters.
    logic [SCORE_BITS-1:0] set_score [MAX_ITEMS];
    logic                  set_label [MAX_ITEMS];
    int                    set_len;
    int                    set_pos;
    logic                  set_dropped;
    logic [CLASS_BITS-1:0] cur_target;
    int                    walk_order [MAX_ITEMS];
    t_result               area_q [$];
    int                    errors;

    // Precision in Q1.16, rounded to nearest with halves up.
    function automatic longint unsigned precision(input longint unsigned tp,
                                                  input longint unsigned pp);
        if (pp == 0)
            return 0;
        return (tp * 131072 + pp) / (2 * pp);
    endfunction

    // Sorts the loaded set by ascending score (ties in arrival order) and
    // integrates the precision-recall curve over it.
    function automatic t_result predict_area();
        t_result         r;
        longint unsigned tp;
        longint unsigned pp;
        longint unsigned qprev;
        longint unsigned q;
        longint unsigned acc;
        longint unsigned a;
        int              key;
        int              j;
        r = '0;
        r.overflowed = set_dropped;
        if (set_pos == 0) begin
            r.no_positives = 1'b1;
            return r;
        end
        if (set_len < 2)
            return r;
        for (int i = 0; i < set_len; i++) begin
            key = i;
            j = i - 1;
            while (j >= 0 && set_score[walk_order[j]] > set_score[key]) begin
                walk_order[j + 1] = walk_order[j];
                j--;
            end
            walk_order[j + 1] = key;
        end
        tp = set_pos;
        pp = set_len;
        qprev = precision(tp, pp);
        acc = 0;
        for (int i = 0; i + 1 < set_len; i++) begin
            pp--;
            if (set_label[walk_order[i]] && tp > 0)
                tp--;
            q = precision(tp, pp);
            if (set_label[walk_order[i]])
                acc += qprev + q;
            qprev = q;
        end
        a = (acc + set_pos) / (2 * longint'(set_pos));
        if (a > 65536)
            a = 65536;
        r.area = a[AREA_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            set_len     = 0;
            set_pos     = 0;
            set_dropped = 1'b0;
            cur_target  = '0;
            area_q.delete();
            errors      = 0;
        end else begin
            // Result beats are checked against the oldest prediction.
            if (i_res_strobe) begin
                if (area_q.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    errors++;
                end else begin
                    want = area_q.pop_front();
                    if (i_result.area !== want.area) begin
                        $error("area: expected %0d, got %0d", want.area, i_result.area);
                        errors++;
                    end
                    if (i_result.no_positives !== want.no_positives) begin
                        $error("no_positives: expected %0d, got %0d",
                               want.no_positives, i_result.no_positives);
                        errors++;
                    end
                    if (i_result.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0d, got %0d",
                               want.overflowed, i_result.overflowed);
                        errors++;
                    end
                end
            end
            // Accepted item beat: store it, and on the last one predict the result.
            if (start && !busy) begin
                if (set_len < MAX_ITEMS) begin
                    set_score[set_len] = i_item.score;
                    set_label[set_len] = (i_item.true_class == cur_target);
                    if (i_item.true_class == cur_target)
                        set_pos++;
                    set_len++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_item.last_item) begin
                    area_q = {area_q, predict_area()};
                    set_len     = 0;
                    set_pos     = 0;
                    set_dropped = 1'b0;
                end
            end
            if (i_cfg_we)
                cur_target = i_cfg_wdata;
        end
        o_fail_count <= errors;
        o_pending    <= area_q.size();
    end

endmodule

@@ test/precision_recall_area_unit_tb.sv @@
// Testbench top for the precision-recall area unit: clock, reset, item and config stimulus.
// Depends on pra_pkg, precision_recall_area_unit and precision_recall_area_checker.
`timescale 1ns / 1ps
module precision_recall_area_unit_tb;
    import pra_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  i_cfg_we;
    logic [CLASS_BITS-1:0] i_cfg_wdata;
    t_result               o_result;
    logic                  o_res_strobe;
    int                    fail_count;
    int                    pending;
    longint                cycles = 0;
    int                    burst_left;
    int                    items_sent;
    logic [CLASS_BITS-1:0] tgt;

    precision_recall_area_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_result     (o_result),
        .o_res_strobe (o_res_strobe)
    );

    precision_recall_area_checker area_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_result     (o_result),
        .i_res_strobe (o_res_strobe),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("precision_recall_area_unit: mismatch");
            $finish;
        end
    end

    // Sends one item beat; the sender works in bursts with idle gaps between.
    task automatic send_item(input logic [SCORE_BITS-1:0] sc,
                             input logic [CLASS_BITS-1:0] cl,
                             input logic lst);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        start  <= 1'b1;
        i_item <= '{score: sc, true_class: cl, last_item: lst};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Writes the target class once the block has nothing left to deliver.
    task automatic write_target(input logic [CLASS_BITS-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        tgt = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CLASS_BITS-1:0] pick_class();
        case ($urandom_range(0, 3))
            0, 1:    return tgt;
            2:       return tgt ^ CLASS_BITS'(1 << $urandom_range(0, CLASS_BITS - 1));
            default: return CLASS_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [SCORE_BITS-1:0] pick_score();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCORE_BITS'($urandom_range(0, 3) * 16384);
            default: return SCORE_BITS'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        burst_left  = 0;
        items_sent  = 0;
        tgt         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single positive item under the reset target: empty walk, area zero.
        send_item(16'h8000, 8'd0, 1'b1);
        // No positives in the set.
        send_item(16'h0000, 8'd5, 1'b0);
        send_item(16'hFFFF, 8'd255, 1'b1);
        // Extremes, tied scores and a mix of labels under target 255.
        write_target(8'd255);
        send_item(16'hFFFF, 8'd255, 1'b0);
        send_item(16'h0000, 8'd0, 1'b0);
        send_item(16'h4000, 8'd255, 1'b0);
        send_item(16'h4000, 8'd1, 1'b0);
        send_item(16'h4000, 8'd255, 1'b0);
        send_item(16'h0000, 8'd255, 1'b1);
        // Target changed partway through a set: earlier labels stand.
        write_target(8'd0);
        send_item(16'h1234, 8'd0, 1'b0);
        send_item(16'hABCD, 8'd7, 1'b0);
        write_target(8'd7);
        send_item(16'h5555, 8'd7, 1'b0);
        send_item(16'h0001, 8'd0, 1'b0);
        send_item(16'hFFFE, 8'd7, 1'b1);
        // Every item positive.
        send_item(16'h0010, 8'd7, 1'b0);
        send_item(16'h0100, 8'd7, 1'b0);
        send_item(16'h1000, 8'd7, 1'b1);

        // Random data sets, mostly small.
        while (items_sent < 520) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_target(8'd0);
                    1:       write_target(8'd255);
                    default: write_target(CLASS_BITS'($urandom));
                endcase
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && i > 0 && $urandom_range(0, 9) == 0)
                    write_target(CLASS_BITS'($urandom));
                send_item(pick_score(), pick_class(), i == n - 1);
            end
        end

        // Store filled to capacity: the last two items are dropped, the final one
        // still closes the set.
        for (int i = 0; i < MAX_ITEMS + 2; i++)
            send_item(SCORE_BITS'($urandom), pick_class(), i == MAX_ITEMS + 1);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("precision_recall_area_unit: match");
        end else begin
            $display("precision_recall_area_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/pra_pkg.sv
rtl/pra_div.sv
rtl/pra_ctrl.sv
rtl/pra_dp.sv
rtl/precision_recall_area_unit.sv
test/precision_recall_area_checker.sv
test/precision_recall_area_unit_tb.sv
